/* hdl/wert_pkg.sv */
// Shared types and constants for the windowed event-rate trigger.
package wert_pkg;

  localparam logic [31:0] ALL_ONES_32 = 32'hFFFF_FFFF;
  localparam logic [6:0]  TOTAL_MAX   = 7'h7F;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ID_LOW        = 3'd0,
    CFG_ID_HIGH       = 3'd1,
    CFG_SEVERITY_MASK = 3'd2,
    CFG_REPEAT_NEEDED = 3'd3,
    CFG_WINDOW_SECS   = 3'd4,
    CFG_CLEAR_ON_TRIG = 3'd5,
    CFG_INVERT_PAT    = 3'd6
  } cfg_idx_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_CMP,
    ST_APPEND,
    ST_FINISH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;   // capture input transfer
    logic eval;    // settle result for no-hit or window-off events
    logic rd;      // read oldest window entry
    logic pop;     // drop oldest window entry
    logic append;  // write new hit time, settle windowed result
    logic load;    // move result into output register, bump totals
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;       // event passes filter and pattern check
    logic win_off;   // window disabled by configuration
    logic held_nz;   // window holds at least one entry
    logic held_gt1;  // window holds more than one entry
    logic expired;   // entry just read is older than the window
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

/* hdl/wert_ctrl.sv */
// Controller state machine for the windowed event-rate trigger.
module wert_ctrl
  import wert_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!sts.hit || sts.win_off) begin
          cmd.eval  = 1'b1;
          state_nxt = ST_FINISH;
        end else if (sts.held_nz) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_APPEND;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (sts.expired) begin
          cmd.pop   = 1'b1;
          state_nxt = sts.held_gt1 ? ST_READ : ST_APPEND;
        end else begin
          state_nxt = ST_APPEND;
        end
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/wert_dp.sv */
// Datapath: configuration, filter, hit-time window store, totals, output register.
module wert_dp
  import wert_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64
)(
  input  logic         clk,
  input  logic         rst_n,
  input  cmd_t         cmd,
  output sts_t         sts,
  // configuration writes
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  // input item
  input  logic         in_filter_on,
  input  logic [31:0]  in_event_id,
  input  logic [31:0]  in_severity,
  input  logic [31:0]  in_now_seconds,
  input  logic         in_pattern_hit,
  // result
  output logic         out_valid,
  input  logic         out_ready,
  output logic         out_triggered,
  output logic [6:0]   out_repeat_total,
  output logic [31:0]  out_checked_total,
  output logic [31:0]  out_matched_total
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

  // Configuration registers
  logic [31:0] id_low_r, id_high_r, sev_mask_r, window_secs_r;
  logic [6:0]  repeat_needed_r;
  logic        clear_on_trig_r, invert_pat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_low_r        <= '0;
      id_high_r       <= ALL_ONES_32;
      sev_mask_r      <= ALL_ONES_32;
      repeat_needed_r <= '0;
      window_secs_r   <= '0;
      clear_on_trig_r <= 1'b0;
      invert_pat_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ID_LOW:        id_low_r        <= cfg_data;
        CFG_ID_HIGH:       id_high_r       <= cfg_data;
        CFG_SEVERITY_MASK: sev_mask_r      <= cfg_data;
        CFG_REPEAT_NEEDED: repeat_needed_r <= cfg_data[6:0];
        CFG_WINDOW_SECS:   window_secs_r   <= cfg_data;
        CFG_CLEAR_ON_TRIG: clear_on_trig_r <= cfg_data[0];
        CFG_INVERT_PAT:    invert_pat_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Captured input item
  logic        filt_r, pat_r;
  logic [31:0] id_r, sev_r, now_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      filt_r <= in_filter_on;
      id_r   <= in_event_id;
      sev_r  <= in_severity;
      now_r  <= in_now_seconds;
      pat_r  <= in_pattern_hit;
    end
  end

  // Filter and pattern check
  logic pass;
  assign pass = !filt_r ||
                ((id_r >= id_low_r) && (id_r <= id_high_r) && ((sev_r & sev_mask_r) != '0));

  // Window store and its pointers
  logic [31:0]      mem [WINDOW_DEPTH];
  logic [31:0]      rdata_r;
  logic [IDX_W-1:0] oldest_r;
  logic [CNT_W-1:0] held_r;

  logic [IDX_W-1:0] oldest_inc;
  logic [SUM_W-1:0] wsum;
  logic [IDX_W-1:0] waddr;
  logic             full;
  logic [CNT_W-1:0] held_new;
  logic             fire_win;
  logic [CMP_W-1:0] held_ext;

  assign oldest_inc = (oldest_r == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_r + IDX_W'(1);
  assign full       = (held_r == CNT_W'(WINDOW_DEPTH));
  assign wsum       = SUM_W'(oldest_r) + SUM_W'(held_r);
  assign held_new   = full ? held_r : held_r + CNT_W'(1);
  assign held_ext   = CMP_W'(held_new);
  assign fire_win   = (held_ext >= CMP_W'(repeat_needed_r));

  // Write slot: oldest + held, wrapped; a full store overwrites its oldest entry
  always_comb begin
    if (full) begin
      waddr = oldest_r;
    end else if (wsum >= SUM_W'(WINDOW_DEPTH)) begin
      waddr = IDX_W'(wsum - SUM_W'(WINDOW_DEPTH));
    end else begin
      waddr = IDX_W'(wsum);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[waddr] <= now_r;
    end
    if (cmd.rd) begin
      rdata_r <= mem[oldest_r];
    end
  end

  // Oldest pointer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      held_r   <= '0;
    end else if (cmd.pop) begin
      oldest_r <= oldest_inc;
      held_r   <= held_r - CNT_W'(1);
    end else if (cmd.append) begin
      if (fire_win && clear_on_trig_r) begin
        oldest_r <= '0;
        held_r   <= '0;
      end else begin
        oldest_r <= full ? oldest_inc : oldest_r;
        held_r   <= held_new;
      end
    end
  end

  // Expiry: entry time plus window, without wrap, below now
  logic expired;
  assign expired = ({1'b0, rdata_r} + {1'b0, window_secs_r}) < {1'b0, now_r};

  // Result of the item in flight
  logic       res_fire_r;
  logic [6:0] res_total_r;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_fire_r  <= pass && (pat_r ^ invert_pat_r);
      res_total_r <= {6'd0, pass && (pat_r ^ invert_pat_r)};
    end else if (cmd.append) begin
      res_fire_r  <= fire_win;
      res_total_r <= !fire_win ? 7'd0 :
                     (held_ext > CMP_W'(TOTAL_MAX)) ? TOTAL_MAX : held_ext[6:0];
    end
  end

  // Saturating totals and output register
  logic [31:0] checked_r, matched_r;
  logic        out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      checked_r   <= '0;
      matched_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        out_valid_r <= 1'b1;
        if (checked_r != ALL_ONES_32) begin
          checked_r <= checked_r + 32'd1;
        end
        if (res_fire_r && (matched_r != ALL_ONES_32)) begin
          matched_r <= matched_r + 32'd1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_triggered    <= res_fire_r;
      out_repeat_total <= res_total_r;
    end
  end

  assign out_checked_total = checked_r;
  assign out_matched_total = matched_r;
  assign out_valid         = out_valid_r;

  // Status to controller
  assign sts.hit      = pass && (pat_r ^ invert_pat_r);
  assign sts.win_off  = (repeat_needed_r == '0) || (window_secs_r == '0);
  assign sts.held_nz  = (held_r != '0);
  assign sts.held_gt1 = (held_r > CNT_W'(1));
  assign sts.expired  = expired;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

/* hdl/windowed_event_rate_trigger_core.sv */
// Top level of the windowed event-rate trigger.
//
// Usage: one log event per transfer on the in_ stream; one result per event
// on the out_ stream, in order. Registers are written on the cfg_ channel
// (cfg_ready is always high); the user must write them only while the block is
// idle, since the block itself does not enforce this. An unknown index is ignored.
// Steps after an event is accepted: a rejected event, a no-hit or a disabled
// window is settled (EVAL), then loaded (FINISH); a windowed hit on an empty
// window is appended (APPEND), then loaded; on a non-empty window the oldest
// entry is read (READ) and compared (CMP), each expired entry is dropped and the
// next one read, until one is not expired or none is left, then the hit is
// appended and loaded. Each entry looked at costs one read of the store, which
// has one read port with a registered output, and one compare. A new event can be
// taken in the cycle after the previous result has moved into the output
// register, not before; expiries average out to at most one per appended hit.
// Reset: the window is emptied, totals cleared and registers return to their
// defaults; the store contents themselves are not cleared, only held entries
// are read. When the receiver stalls, the result waits in the output register
// and the next event is worked up to the point of delivery, then holds.
module windowed_event_rate_trigger_core
  import wert_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64
)(
  input  logic          clk,
  input  logic          rst_n,
  // configuration write channel
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  // event input stream
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [103:0]  in_tdata,  // event_id[31:0], severity[63:32], now_seconds[95:64],
                                   // pattern_hit[96], zero[103:97]
  input  logic          in_tuser,  // filter_on[0]
  // result stream
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [71:0]   out_tdata  // triggered[0], repeat_total[7:1],
                                   // checked_total[39:8], matched_total[71:40]
);

  cmd_t cmd;
  sts_t sts;

  logic        trig;
  logic [6:0]  total;
  logic [31:0] checked, matched;

  assign cfg_ready = 1'b1;

  wert_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wert_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_filter_on      (in_tuser),
    .in_event_id       (in_tdata[31:0]),
    .in_severity       (in_tdata[63:32]),
    .in_now_seconds    (in_tdata[95:64]),
    .in_pattern_hit    (in_tdata[96]),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .out_triggered     (trig),
    .out_repeat_total  (total),
    .out_checked_total (checked),
    .out_matched_total (matched)
  );

  assign out_tdata = {matched, checked, total, trig};

endmodule
